// ===== rtl/hslp_pkg.sv =====
// hslp_pkg: shared types and constants for the linear-probe hash set.
// Used by hslp_mod, hslp_table and hash_set_linear_probe_core.
package hslp_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 128;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = SLOT_W + 1;          // holds 0..TABLE_DEPTH
   localparam int KEY_W       = 32;
   localparam int BITCNT_W    = $clog2(KEY_W);
   localparam int SIZE_W      = 8;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

   // operation codes
   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // slot marks
   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_FILLED  = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   // table access from the controller
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_key_en;
      logic              wr_mark_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_key;
      mark_type          wr_mark;
   } tbl_req_type;

   // registered read data from the table
   typedef struct packed {
      mark_type         mark;
      logic [KEY_W-1:0] key;
   } tbl_rsp_type;

endpackage

// ===== rtl/hash_set_linear_probe_core.sv =====
// hash_set_linear_probe_core: top level of the linear-probe hash set.
// Instantiates hslp_mod and hslp_table; uses hslp_pkg.
//
//   channel | dir | handshake                | payload
//   req     | in  | req_tvalid / req_tready  | tuser: op, tdata: key
//   rsp     | out | rsp_tvalid / rsp_tready  | tdata: ok
//   csr     | in  | csr_we                   | csr_wdata: table_size
//
// An item is accepted, its key reduced mod table_size in the bit-serial mod
// unit, then each probed slot (1..table_size) is read from memory and checked.
// An invalid op skips the mod unit and the probe and answers with ok clear.
// Reset is synchronous; slot marks read as empty through per-slot valid
// bits, so no clearing pass is needed. A result waiting on rsp_tready does
// not block accepting the next item; only finishing it waits.
module hash_set_linear_probe_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [1:0]  req_tuser,   // [1:0] op
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] ok, [7:1] zero
   // configuration
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata    // table_size
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [1:0]                      op_ff, op_in;
   logic [hslp_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [hslp_pkg::CNT_W-1:0]      n_ff, n_in;
   logic [hslp_pkg::SLOT_W-1:0]     pos_ff, pos_in;
   logic [hslp_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            ok_ff, ok_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [hslp_pkg::SIZE_W-1:0]     size_ff;

   logic [hslp_pkg::CNT_W-1:0]      live_n;
   logic                            accept;
   logic                            op_valid;
   logic                            mod_start;
   logic                            mod_done;
   logic [hslp_pkg::SLOT_W-1:0]     mod_rem;
   logic [hslp_pkg::CNT_W-1:0]      pos_inc;
   logic [hslp_pkg::CNT_W-1:0]      cnt_inc;
   logic                            hit;
   hslp_pkg::tbl_req_type           tbl_req;
   hslp_pkg::tbl_rsp_type           tbl_rsp;

   // table size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= hslp_pkg::SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   // clamp size to 1..TABLE_DEPTH
   always_comb begin
      if (size_ff == '0) begin
         live_n = hslp_pkg::CNT_W'(1);
      end else if (32'(size_ff) > 32'(hslp_pkg::TABLE_DEPTH)) begin
         live_n = hslp_pkg::CNT_W'(hslp_pkg::TABLE_DEPTH);
      end else begin
         live_n = hslp_pkg::CNT_W'(size_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign op_valid   = (req_tuser == hslp_pkg::OP_FIND) || (req_tuser == hslp_pkg::OP_ADD) ||
                       (req_tuser == hslp_pkg::OP_REMOVE);
   assign mod_start  = accept && op_valid;

   hslp_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_tdata),
      .divisor   (live_n),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   hslp_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp)
   );

   assign pos_inc = {1'b0, pos_ff} + 1'b1;
   assign cnt_inc = cnt_ff + 1'b1;
   assign hit     = (tbl_rsp.mark == hslp_pkg::MARK_FILLED) && (tbl_rsp.key == key_ff);

   // probe sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      n_in         = n_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;

      tbl_req            = '0;
      tbl_req.rd_addr    = pos_ff;
      tbl_req.wr_addr    = pos_ff;
      tbl_req.wr_key     = key_ff;
      tbl_req.wr_mark    = hslp_pkg::MARK_FILLED;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_tuser;
               key_in = req_tdata;
               n_in   = live_n;
               ok_in  = 1'b0;
               state_in = op_valid ? ST_HASH : ST_DONE;
            end
         end
         ST_HASH: begin
            if (mod_done) begin
               pos_in   = mod_rem;
               cnt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            tbl_req.rd_en = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_READ;
            // step to the next slot with wraparound
            pos_in   = (pos_inc == n_ff) ? '0 : pos_inc[hslp_pkg::SLOT_W-1:0];
            cnt_in   = cnt_inc;
            if (cnt_inc == n_ff) begin
               state_in = ST_DONE;
            end
            if (op_ff == hslp_pkg::OP_ADD) begin
               if (tbl_rsp.mark == hslp_pkg::MARK_EMPTY ||
                   tbl_rsp.mark == hslp_pkg::MARK_DELETED) begin
                  tbl_req.wr_key_en  = 1'b1;
                  tbl_req.wr_mark_en = 1'b1;
                  ok_in    = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               if (hit) begin
                  ok_in    = 1'b1;
                  state_in = ST_DONE;
                  if (op_ff == hslp_pkg::OP_REMOVE) begin
                     tbl_req.wr_mark_en = 1'b1;
                     tbl_req.wr_mark    = hslp_pkg::MARK_DELETED;
                  end
               end else if (tbl_rsp.mark == hslp_pkg::MARK_EMPTY) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      n_ff      <= n_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      ok_ff     <= ok_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ok_ff};

endmodule

// ===== rtl/hslp_mod.sv =====
// hslp_mod: bit-serial key mod table-size unit, one key bit per cycle.
// Depends on hslp_pkg.
module hslp_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hslp_pkg::KEY_W-1:0]    dividend,
   input  logic [hslp_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [hslp_pkg::SLOT_W-1:0]   remainder
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [hslp_pkg::BITCNT_W-1:0]   cnt_ff, cnt_in;
   logic [hslp_pkg::KEY_W-1:0]      dvd_ff, dvd_in;
   logic [hslp_pkg::CNT_W-1:0]      dvs_ff, dvs_in;
   logic [hslp_pkg::CNT_W-1:0]      rem_ff, rem_in;
   logic [hslp_pkg::CNT_W-1:0]      partial;

   // restoring step: shift in the next key bit, subtract when it fits
   always_comb begin
      partial = {rem_ff[hslp_pkg::SLOT_W-1:0], dvd_ff[hslp_pkg::KEY_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = hslp_pkg::BITCNT_W'(hslp_pkg::KEY_W - 1);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[hslp_pkg::KEY_W-2:0], 1'b0};
         rem_in = (partial >= dvs_ff) ? partial - dvs_ff : partial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[hslp_pkg::SLOT_W-1:0];

endmodule

// ===== rtl/hslp_table.sv =====
// hslp_table: slot key and slot mark memories with a registered read.
// Marks read as empty until a slot's valid bit is set. Depends on hslp_pkg.
module hslp_table (
   input  logic                  clock,
   input  logic                  reset,
   input  hslp_pkg::tbl_req_type tbl_req,
   output hslp_pkg::tbl_rsp_type tbl_rsp
);

   logic [hslp_pkg::KEY_W-1:0] key_mem  [hslp_pkg::TABLE_DEPTH];
   hslp_pkg::mark_type         mark_mem [hslp_pkg::TABLE_DEPTH];
   logic [hslp_pkg::TABLE_DEPTH-1:0] valid_ff;

   logic [hslp_pkg::KEY_W-1:0] rd_key_ff;
   hslp_pkg::mark_type         rd_mark_ff;
   logic                       rd_valid_ff;

   // per-slot valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (tbl_req.wr_mark_en) begin
         valid_ff[tbl_req.wr_addr] <= 1'b1;
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (tbl_req.wr_key_en) begin
         key_mem[tbl_req.wr_addr] <= tbl_req.wr_key;
      end
      if (tbl_req.wr_mark_en) begin
         mark_mem[tbl_req.wr_addr] <= tbl_req.wr_mark;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_key_ff   <= key_mem[tbl_req.rd_addr];
         rd_mark_ff  <= mark_mem[tbl_req.rd_addr];
         rd_valid_ff <= valid_ff[tbl_req.rd_addr];
      end
   end

   assign tbl_rsp.key  = rd_key_ff;
   assign tbl_rsp.mark = rd_valid_ff ? rd_mark_ff : hslp_pkg::MARK_EMPTY;

endmodule
